@@ sv/bba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_POOL = 3'd1;
   localparam logic [2:0] ST_NO_MEM   = 3'd2;
   localparam logic [2:0] ST_BAD_ADDR = 3'd3;
   localparam logic [2:0] ST_BAD_FREE = 3'd4;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_LATCH,
      OP_SETUP,
      OP_SETUP2,
      OP_SCAN_DEC,
      OP_SCAN_TAKE,
      OP_A_STEP,
      OP_A_OFF,
      OP_F_PR,
      OP_F_DEC,
      OP_F_B,
      OP_F_RDB,
      OP_F_HIT,
      OP_F_RMB,
      OP_F_MRG,
      OP_F_TGR,
      OP_F_ROOT,
      OP_M_RB,
      OP_M_RMB,
      OP_M_RMK,
      OP_M_DESC,
      OP_M_BLK,
      OP_TG_RD,
      OP_TG_WR,
      OP_LR_RD,
      OP_LR_WR,
      OP_LP_A,
      OP_LP_B
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       st_we;
      logic [2:0] st_code;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic pool_bad;
      logic is_free;
      logic too_big;
      logic bad_off;
      logic head_nil;
      logic co_zero;
      logic o_over;
      logic cur_zero;
      logic cur_one;
      logic used_rd;
      logic used_p;
   } status_type;

endpackage
`default_nettype wire

@@ sv/buddy_block_allocator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-pool buddy allocator.
// Request: drive req_mode (0 allocate, 1 free), req_pool, req_size_bytes or
// req_free_offset with start; the word is taken on the edge where start is
// high and busy is low. Pools 2 and 3 are rejected with a bad-pool status.
// Response: rsp_valid pulses for one cycle with rsp_status and
// rsp_alloc_offset; the receiver cannot stall, so the word must be taken then.
// Steps: every memory step goes through a single registered read port per
// node array. A bad pool, size or address is refused without touching the
// node arrays. An allocate scans the empty orders, then splits one level at
// a time. A free walks up the orders past free and split parents, then
// releases a block whose buddy is in use or the root, or merges it with its
// buddy, repeating while the buddy above is free.
// One request is in flight at a time; busy stays high until the response.
// Reset: a clearing pass writes every node entry, 2302 entries with the
// default sizes (total tree nodes of both pools); busy is high meanwhile,
// then each pool root sits alone on its order-0 free list.
module buddy_block_allocator_top import bba_pkg::*; #(
   parameter int LEVELS_POOL0 = 7,
   parameter int LEVELS_POOL1 = 10,
   parameter int UNIT_BYTES   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_mode,
   input  wire logic [1:0]  req_pool,
   input  wire logic [19:0] req_size_bytes,
   input  wire logic [15:0] req_free_offset,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_alloc_offset
);

   cmd_type    cmd;
   status_type stat;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bba_dp #(
      .LEVELS_POOL0 (LEVELS_POOL0),
      .LEVELS_POOL1 (LEVELS_POOL1),
      .UNIT_BYTES   (UNIT_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_mode),
      .req_pool         (req_pool),
      .req_size_bytes   (req_size_bytes),
      .req_free_offset  (req_free_offset),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_alloc_offset (rsp_alloc_offset)
   );

endmodule
`default_nettype wire

@@ sv/bba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl import bba_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type stat,
   output cmd_type         cmd,
   output logic            busy,
   output logic            rsp_valid
);

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_SETUP, S_SETUP2, S_DISP, S_SCAN, S_ALOOP,
      S_FTOP, S_FR, S_FP, S_FD, S_F2, S_F3, S_FIN,
      S_MTOP, S_MR, S_M2, S_M3, S_M4,
      S_TGR, S_TGW, S_LRR, S_LRW, S_LPA, S_LPB
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic      lr_job_ff, lr_job_in, push_job_ff, push_job_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      lr_job_in    = lr_job_ff;
      push_job_in  = push_job_ff;
      rsp_valid_in = 1'b0;
      cmd.op       = OP_IDLE;
      cmd.st_we    = 1'b0;
      cmd.st_code  = ST_OK;
      unique case (state_ff)
         S_CLR: begin
            cmd.op = OP_CLEAR;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LATCH;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (stat.pool_bad) begin
               cmd.st_we = 1'b1; cmd.st_code = ST_BAD_POOL;
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end else begin
               cmd.op   = OP_SETUP;
               state_in = S_SETUP2;
            end
         end
         S_SETUP2: begin
            cmd.op   = OP_SETUP2;
            state_in = S_DISP;
         end
         S_DISP: begin
            if (!stat.is_free) begin
               if (stat.too_big) begin
                  cmd.st_we = 1'b1; cmd.st_code = ST_NO_MEM;
                  rsp_valid_in = 1'b1; state_in = S_IDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               if (stat.bad_off) begin
                  cmd.st_we = 1'b1; cmd.st_code = ST_BAD_ADDR;
                  rsp_valid_in = 1'b1; state_in = S_IDLE;
               end else begin
                  state_in = S_FTOP;
               end
            end
         end
         S_SCAN: begin
            if (stat.head_nil) begin
               if (stat.co_zero) begin
                  cmd.st_we = 1'b1; cmd.st_code = ST_NO_MEM;
                  rsp_valid_in = 1'b1; state_in = S_IDLE;
               end else begin
                  cmd.op = OP_SCAN_DEC;
               end
            end else begin
               cmd.op = OP_SCAN_TAKE;
               lr_job_in = 1'b1; push_job_in = 1'b0;
               ret_in = S_ALOOP; state_in = S_TGR;
            end
         end
         S_ALOOP: begin
            if (stat.o_over) begin
               cmd.op = OP_A_OFF;
               cmd.st_we = 1'b1; cmd.st_code = ST_OK;
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end else begin
               cmd.op = OP_A_STEP;
               lr_job_in = 1'b1; push_job_in = 1'b1;
               ret_in = S_ALOOP; state_in = S_TGR;
            end
         end
         S_FTOP: begin
            if (stat.cur_zero) begin
               cmd.st_we = 1'b1; cmd.st_code = ST_BAD_FREE;
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end else begin
               cmd.op   = OP_F_PR;
               state_in = S_FR;
            end
         end
         S_FR: begin
            if (!stat.used_rd) begin
               cmd.op   = OP_F_DEC;
               state_in = S_FTOP;
            end else begin
               cmd.op   = OP_F_B;
               state_in = S_FP;
            end
         end
         S_FP: begin
            cmd.op   = OP_F_RDB;
            state_in = S_FD;
         end
         S_FD: begin
            priority if (stat.used_p && stat.used_rd) begin
               cmd.op = OP_F_HIT;
               lr_job_in = 1'b1; push_job_in = 1'b1;
               ret_in = S_FIN; state_in = S_TGR;
            end else if (stat.used_p) begin
               cmd.op = OP_F_RMB;
               lr_job_in = 1'b1; push_job_in = 1'b0;
               ret_in = S_F2; state_in = S_LRR;
            end else if (stat.used_rd) begin
               cmd.st_we = 1'b1; cmd.st_code = ST_BAD_FREE;
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end else if (stat.cur_one) begin
               cmd.op = OP_F_ROOT;
               lr_job_in = 1'b1; push_job_in = 1'b1;
               ret_in = S_FIN; state_in = S_TGR;
            end else begin
               cmd.op   = OP_F_DEC;
               state_in = S_FTOP;
            end
         end
         S_F2: begin
            cmd.op = OP_F_MRG;
            lr_job_in = 1'b1; push_job_in = 1'b1;
            ret_in = S_F3; state_in = S_TGR;
         end
         S_F3: begin
            cmd.op = OP_F_TGR;
            lr_job_in = 1'b0; push_job_in = 1'b0;
            ret_in = S_MTOP; state_in = S_TGR;
         end
         S_FIN: begin
            cmd.st_we = 1'b1; cmd.st_code = ST_OK;
            rsp_valid_in = 1'b1; state_in = S_IDLE;
         end
         S_MTOP: begin
            if (stat.cur_zero) begin
               cmd.st_we = 1'b1; cmd.st_code = ST_OK;
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end else begin
               cmd.op   = OP_M_RB;
               state_in = S_MR;
            end
         end
         S_MR: begin
            if (stat.used_rd) begin
               cmd.st_we = 1'b1; cmd.st_code = ST_OK;
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end else begin
               cmd.op = OP_M_RMB;
               lr_job_in = 1'b1; push_job_in = 1'b0;
               ret_in = S_M2; state_in = S_LRR;
            end
         end
         S_M2: begin
            cmd.op = OP_M_RMK;
            lr_job_in = 1'b1; push_job_in = 1'b0;
            ret_in = S_M3; state_in = S_LRR;
         end
         S_M3: begin
            cmd.op   = OP_M_DESC;
            state_in = S_M4;
         end
         S_M4: begin
            cmd.op = OP_M_BLK;
            lr_job_in = 1'b1; push_job_in = 1'b1;
            ret_in = S_MTOP; state_in = S_TGR;
         end
         S_TGR: begin
            cmd.op   = OP_TG_RD;
            state_in = S_TGW;
         end
         S_TGW: begin
            cmd.op   = OP_TG_WR;
            state_in = lr_job_ff ? S_LRR : ret_ff;
         end
         S_LRR: begin
            cmd.op   = OP_LR_RD;
            state_in = S_LRW;
         end
         S_LRW: begin
            cmd.op   = OP_LR_WR;
            state_in = push_job_ff ? S_LPA : ret_ff;
         end
         S_LPA: begin
            cmd.op   = OP_LP_A;
            state_in = S_LPB;
         end
         S_LPB: begin
            cmd.op   = OP_LP_B;
            state_in = ret_ff;
         end
         default: state_in = S_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         ret_ff       <= S_IDLE;
         lr_job_ff    <= 1'b0;
         push_job_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         lr_job_ff    <= lr_job_in;
         push_job_ff  <= push_job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ sv/bba_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bba_dp import bba_pkg::*; #(
   parameter int LEVELS_POOL0 = 7,
   parameter int LEVELS_POOL1 = 10,
   parameter int UNIT_BYTES   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire logic        req_mode,
   input  wire logic [1:0]  req_pool,
   input  wire logic [19:0] req_size_bytes,
   input  wire logic [15:0] req_free_offset,
   output status_type       stat,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_alloc_offset
);

   localparam int LMAX = (LEVELS_POOL0 > LEVELS_POOL1) ? LEVELS_POOL0 : LEVELS_POOL1;
   localparam int NW   = LMAX + 1;
   localparam int OW   = $clog2(LMAX + 2);
   localparam int UW   = LMAX;
   localparam int N0   = (2 << LEVELS_POOL0) - 1;
   localparam int N1   = (2 << LEVELS_POOL1) - 1;
   localparam int NT   = N0 + N1;
   localparam int GW   = $clog2(NT);
   localparam int NORD = LEVELS_POOL0 + LEVELS_POOL1 + 2;
   localparam int HW   = $clog2(NORD);
   localparam int CU   = $clog2(UNIT_BYTES);
   localparam int RM   = (1 << 24) / UNIT_BYTES;
   localparam logic [31:0] PB0 = 32'(UNIT_BYTES) << LEVELS_POOL0;
   localparam logic [31:0] PB1 = 32'(UNIT_BYTES) << LEVELS_POOL1;
   localparam logic [NW-1:0] NIL = '1;

   logic          used_mem   [NT];
   logic          linked_mem [NT];
   logic [NW-1:0] next_mem   [NT];
   logic [NW-1:0] prev_mem   [NT];
   logic [NW-1:0] head_ff    [NORD];

   logic          mode_ff, used_p_ff;
   logic [1:0]    pool_ff;
   logic [19:0]   size_ff;
   logic [15:0]   off_ff, uq_ff, res_ff;
   logic [4:0]    k_ff;
   logic [OW-1:0] want_ff, o_ff, cur_ff, lo_ff;
   logic [UW-1:0] unit_ff;
   logic [NW-1:0] n_ff, p_ff, r_ff, b_ff, blk_ff, tg_ff, ln_ff, h_ff;
   logic [2:0]    st_ff;
   logic [GW-1:0] clr_ff;

   logic          used_rd_ff, linked_rd_ff;
   logic [NW-1:0] next_rd_ff, prev_rd_ff;

   function automatic logic [NW-1:0] node_at(input logic [OW-1:0] ord,
                                             input logic [UW-1:0] u,
                                             input logic [OW-1:0] l);
      node_at = ((NW'(1) << ord) - NW'(1)) + NW'(u >> (l - ord));
   endfunction

   logic          sel1;
   logic [OW-1:0] lv;
   logic [GW-1:0] nb;
   logic [HW-1:0] hidx;
   logic [NW-1:0] head_rd, p_c, r_c, b_c, n_inc, idx_c;
   logic [UW-1:0] bitc, unit_flip, unit_c;
   logic [31:0]   pb, off_prod;
   logic [4:0]    msb, k_c, q_c;
   logic [39:0]   uq_prod;
   logic [24:0]   uqu, rem_c;
   logic [OW-1:0] want_c;

   assign sel1      = pool_ff[0];
   assign lv        = sel1 ? OW'(LEVELS_POOL1) : OW'(LEVELS_POOL0);
   assign nb        = sel1 ? GW'(N0) : '0;
   assign pb        = sel1 ? PB1 : PB0;
   assign hidx      = (sel1 ? HW'(LEVELS_POOL0 + 1) : '0) + HW'(lo_ff);
   assign head_rd   = head_ff[hidx];
   assign bitc      = UW'(1) << (lv - cur_ff);
   assign unit_flip = unit_ff ^ bitc;
   assign p_c       = node_at(cur_ff, unit_ff, lv);
   assign r_c       = (p_c - NW'(1)) >> 1;
   assign b_c       = node_at(cur_ff, unit_flip, lv);
   assign n_inc     = n_ff + NW'(1);
   assign idx_c     = n_inc - (NW'(1) << want_ff);
   assign off_prod  = (32'(idx_c) * 32'(UNIT_BYTES)) << (lv - want_ff);

   always_comb begin
      msb = '0;
      for (int i = 0; i < 20; i++) begin
         if (size_ff[i]) msb = 5'(i);
      end
      k_c = ((size_ff & ~(20'd1 << msb)) != 20'd0) ? msb + 5'd1 : msb;
   end

   assign uq_prod = 40'(off_ff) * 40'(RM);
   assign uqu     = 25'(uq_ff) * 25'(UNIT_BYTES);
   assign rem_c   = 25'(off_ff) - uqu;
   assign unit_c  = UW'(uq_ff + 16'((rem_c >= 25'(UNIT_BYTES)) ? 1 : 0));
   assign q_c     = (k_ff >= 5'(CU)) ? k_ff - 5'(CU) : 5'd0;
   assign want_c  = OW'(6'(lv) - 6'(q_c));

   logic [GW-1:0] rd_addr;
   always_comb begin
      unique case (cmd.op)
         OP_F_PR:  rd_addr = nb + GW'(r_c);
         OP_F_B:   rd_addr = nb + GW'(p_ff);
         OP_F_RDB: rd_addr = nb + GW'(b_ff);
         OP_M_RB:  rd_addr = nb + GW'(b_c);
         OP_TG_RD: rd_addr = nb + GW'(tg_ff);
         OP_LR_RD: rd_addr = nb + GW'(ln_ff);
         default:  rd_addr = nb + GW'(ln_ff);
      endcase
   end

   logic          clearing, is_root;
   logic          used_we, linked_we, next_we, prev_we, head_we;
   logic          used_wd, linked_wd;
   logic [GW-1:0] used_wa, linked_wa, next_wa, prev_wa;
   logic [NW-1:0] next_wd, prev_wd, head_wd;

   assign clearing = (cmd.op == OP_CLEAR);
   assign is_root  = (clr_ff == '0) || (clr_ff == GW'(N0));

   always_comb begin
      used_we = 1'b0; used_wa = nb + GW'(tg_ff); used_wd = ~used_rd_ff;
      linked_we = 1'b0; linked_wa = nb + GW'(ln_ff); linked_wd = 1'b0;
      next_we = 1'b0; next_wa = nb + GW'(prev_rd_ff); next_wd = next_rd_ff;
      prev_we = 1'b0; prev_wa = nb + GW'(next_rd_ff); prev_wd = prev_rd_ff;
      head_we = 1'b0; head_wd = next_rd_ff;
      unique case (cmd.op)
         OP_CLEAR: begin
            used_we = 1'b1; used_wa = clr_ff; used_wd = 1'b0;
            linked_we = 1'b1; linked_wa = clr_ff; linked_wd = is_root;
            next_we = 1'b1; next_wa = clr_ff; next_wd = NIL;
            prev_we = 1'b1; prev_wa = clr_ff; prev_wd = NIL;
         end
         OP_TG_WR: used_we = 1'b1;
         OP_LR_WR: begin
            linked_we = linked_rd_ff;
            if (prev_rd_ff == NIL) head_we = linked_rd_ff;
            else next_we = linked_rd_ff;
            prev_we = linked_rd_ff && (next_rd_ff != NIL);
         end
         OP_LP_A: begin
            linked_we = 1'b1; linked_wd = 1'b1;
            next_we = 1'b1; next_wa = nb + GW'(ln_ff); next_wd = head_rd;
            prev_we = 1'b1; prev_wa = nb + GW'(ln_ff); prev_wd = NIL;
            head_we = 1'b1; head_wd = ln_ff;
         end
         OP_LP_B: begin
            prev_we = (h_ff != NIL); prev_wa = nb + GW'(h_ff); prev_wd = ln_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      used_rd_ff   <= used_mem[rd_addr];
      linked_rd_ff <= linked_mem[rd_addr];
      next_rd_ff   <= next_mem[rd_addr];
      prev_rd_ff   <= prev_mem[rd_addr];
      if (used_we)   used_mem[used_wa]     <= used_wd;
      if (linked_we) linked_mem[linked_wa] <= linked_wd;
      if (next_we)   next_mem[next_wa]     <= next_wd;
      if (prev_we)   prev_mem[prev_wa]     <= prev_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NORD; i++) begin
            head_ff[i] <= ((i == 0) || (i == LEVELS_POOL0 + 1)) ? '0 : NIL;
         end
         clr_ff <= '0;
      end else begin
         if (head_we) head_ff[hidx] <= head_wd;
         if (clearing) clr_ff <= clr_ff + GW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.st_we) st_ff <= cmd.st_code;
      unique case (cmd.op)
         OP_LATCH: begin
            mode_ff <= req_mode;
            pool_ff <= req_pool;
            size_ff <= req_size_bytes;
            off_ff  <= req_free_offset;
            res_ff  <= '0;
         end
         OP_SETUP: begin
            k_ff  <= k_c;
            uq_ff <= uq_prod[39:24];
         end
         OP_SETUP2: begin
            want_ff <= want_c;
            lo_ff   <= want_c;
            cur_ff  <= lv;
            unit_ff <= unit_c;
         end
         OP_SCAN_DEC: lo_ff <= lo_ff - OW'(1);
         OP_SCAN_TAKE: begin
            n_ff  <= head_rd;
            tg_ff <= head_rd;
            ln_ff <= head_rd;
            o_ff  <= lo_ff + OW'(1);
         end
         OP_A_STEP: begin
            n_ff  <= {n_ff[NW-2:0], 1'b1};
            tg_ff <= {n_ff[NW-2:0], 1'b1};
            ln_ff <= {n_inc[NW-2:0], 1'b0};
            lo_ff <= o_ff;
            o_ff  <= o_ff + OW'(1);
         end
         OP_A_OFF: res_ff <= off_prod[15:0];
         OP_F_PR: begin
            p_ff <= p_c;
            r_ff <= r_c;
         end
         OP_F_DEC: cur_ff <= cur_ff - OW'(1);
         OP_F_B:   b_ff <= b_c;
         OP_F_RDB: used_p_ff <= used_rd_ff;
         OP_F_HIT: begin
            tg_ff <= p_ff;
            ln_ff <= p_ff;
            lo_ff <= cur_ff;
         end
         OP_F_RMB, OP_M_RMB: begin
            ln_ff <= b_ff;
            lo_ff <= cur_ff;
         end
         OP_F_MRG: begin
            cur_ff  <= cur_ff - OW'(1);
            unit_ff <= unit_ff & unit_flip;
            ln_ff   <= r_ff;
            lo_ff   <= cur_ff - OW'(1);
            tg_ff   <= p_ff;
            blk_ff  <= r_ff;
         end
         OP_F_TGR: tg_ff <= r_ff;
         OP_F_ROOT: begin
            tg_ff <= r_ff;
            ln_ff <= '0;
            lo_ff <= '0;
         end
         OP_M_RB: b_ff <= b_c;
         OP_M_RMK: begin
            ln_ff <= blk_ff;
            lo_ff <= cur_ff;
         end
         OP_M_DESC: begin
            cur_ff  <= cur_ff - OW'(1);
            unit_ff <= unit_ff & unit_flip;
         end
         OP_M_BLK: begin
            blk_ff <= p_c;
            tg_ff  <= p_c;
            ln_ff  <= p_c;
            lo_ff  <= cur_ff;
         end
         OP_LP_A: h_ff <= head_rd;
         default: ;
      endcase
   end

   assign stat.clr_last = (clr_ff == GW'(NT - 1));
   assign stat.pool_bad = pool_ff[1];
   assign stat.is_free  = mode_ff;
   assign stat.too_big  = 32'(size_ff) > pb;
   assign stat.bad_off  = 32'(off_ff) > (pb - 32'(UNIT_BYTES));
   assign stat.head_nil = (head_rd == NIL);
   assign stat.co_zero  = (lo_ff == '0);
   assign stat.o_over   = (o_ff > want_ff);
   assign stat.cur_zero = (cur_ff == '0);
   assign stat.cur_one  = (cur_ff == OW'(1));
   assign stat.used_rd  = used_rd_ff;
   assign stat.used_p   = used_p_ff;

   assign rsp_status       = st_ff;
   assign rsp_alloc_offset = res_ff;

endmodule
`default_nettype wire

@@ sv/bba_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bba_chk import bba_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [2:0]  rsp_status,
   input wire logic [15:0] rsp_alloc_offset
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted word");

   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_BAD_FREE))
      else $error("undefined status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_alloc_offset == 16'd0))
      else $error("nonzero offset on failed request");

endmodule

bind buddy_block_allocator_top bba_chk u_chk (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_alloc_offset (rsp_alloc_offset)
);
`default_nettype wire
